/* design/stidm_pkg.sv */
// stidm_pkg: shared constants, codes and controller/datapath types for the thread id map
// no dependencies

package stidm_pkg;

	localparam int MAX_ENTRIES  = 16;
	localparam int NUMBER_BITS  = 18;
	localparam int VERSION_BITS = 14;

	localparam int ID_W   = NUMBER_BITS + VERSION_BITS;
	localparam int IDX_W  = $clog2(MAX_ENTRIES);
	localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
	localparam int MODE_W = 2;
	localparam int STAT_W = 3;

	localparam logic [MODE_W-1:0] MODE_CREATE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FIND   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK           = 3'd0;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND    = 3'd1;
	localparam logic [STAT_W-1:0] ST_FULL         = 3'd2;
	localparam logic [STAT_W-1:0] ST_DUPLICATE    = 3'd3;
	localparam logic [STAT_W-1:0] ST_ZERO_VERSION = 3'd4;

	typedef struct packed {
		logic load;
		logic step;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic search_done;
	} stat_t;

endpackage

/* design/stidm_ctrl.sv */
// stidm_ctrl: sequencer for one transaction: load, binary search steps, commit
// depends on stidm_pkg

module stidm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output logic               done,
	input  stidm_pkg::stat_t   stat,
	output stidm_pkg::cmd_t    cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_FINISH
	} state_t;

	state_t state_q;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == S_FINISH);
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_SEARCH;
					end
				end
				S_SEARCH: begin
					if (stat.search_done) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		cmd.load   = (state_q == S_IDLE) && start;
		cmd.step   = (state_q == S_SEARCH) && !stat.search_done;
		cmd.commit = (state_q == S_FINISH);
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

/* design/stidm_dp.sv */
// stidm_dp: sorted slot list, identifier store, slot bitmap, search bounds and result registers
// depends on stidm_pkg

module stidm_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  stidm_pkg::cmd_t                      cmd,
	output stidm_pkg::stat_t                     stat,
	input  logic [stidm_pkg::MODE_W-1:0]         mode,
	input  logic [stidm_pkg::NUMBER_BITS-1:0]    thread_number,
	input  logic [stidm_pkg::VERSION_BITS-1:0]   version,
	output logic [stidm_pkg::STAT_W-1:0]         status,
	output logic [stidm_pkg::IDX_W-1:0]          slot,
	output logic [stidm_pkg::CNT_W-1:0]          entry_count
);

	logic [stidm_pkg::IDX_W-1:0]        sorted_q [stidm_pkg::MAX_ENTRIES];
	logic [stidm_pkg::IDX_W-1:0]        sorted_nxt [stidm_pkg::MAX_ENTRIES];
	logic [stidm_pkg::ID_W-1:0]         ids_q [stidm_pkg::MAX_ENTRIES];
	logic [stidm_pkg::MAX_ENTRIES-1:0]  in_use_q;
	logic [stidm_pkg::MAX_ENTRIES-1:0]  in_use_nxt;
	logic [stidm_pkg::CNT_W-1:0]        count_q;
	logic [stidm_pkg::CNT_W-1:0]        count_nxt;

	logic [stidm_pkg::MODE_W-1:0]       mode_q;
	logic [stidm_pkg::NUMBER_BITS-1:0]  num_q;
	logic [stidm_pkg::VERSION_BITS-1:0] ver_q;
	logic [stidm_pkg::CNT_W-1:0]        lo_q;
	logic [stidm_pkg::CNT_W-1:0]        hi_q;

	logic [stidm_pkg::STAT_W-1:0]       status_q;
	logic [stidm_pkg::IDX_W-1:0]        slot_q;
	logic [stidm_pkg::CNT_W-1:0]        cnt_out_q;

	logic [stidm_pkg::CNT_W:0]          mid_sum;
	logic [stidm_pkg::IDX_W-1:0]        mid;
	logic [stidm_pkg::IDX_W-1:0]        mid_slot;
	logic [stidm_pkg::NUMBER_BITS-1:0]  mid_num;

	logic [stidm_pkg::IDX_W-1:0]        pos_idx;
	logic [stidm_pkg::IDX_W-1:0]        pos_slot;
	logic [stidm_pkg::ID_W-1:0]         pos_id;
	logic [stidm_pkg::ID_W-1:0]         key_id;
	logic                               hit_num;
	logic                               hit_all;

	logic                               free_found;
	logic [stidm_pkg::IDX_W-1:0]        free_slot;

	logic                               do_ins;
	logic                               do_del;
	logic [stidm_pkg::STAT_W-1:0]       res_status;
	logic [stidm_pkg::IDX_W-1:0]        res_slot;

	// search step
	assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid      = mid_sum[stidm_pkg::IDX_W:1];
	assign mid_slot = sorted_q[mid];
	assign mid_num  = ids_q[mid_slot][stidm_pkg::ID_W-1 -: stidm_pkg::NUMBER_BITS];

	assign stat.search_done = (lo_q == hi_q);

	// match at the final position
	assign key_id   = {num_q, ver_q};
	assign pos_idx  = lo_q[stidm_pkg::IDX_W-1:0];
	assign pos_slot = sorted_q[pos_idx];
	assign pos_id   = ids_q[pos_slot];
	assign hit_num  = (lo_q < count_q) &&
		(pos_id[stidm_pkg::ID_W-1 -: stidm_pkg::NUMBER_BITS] == num_q);
	assign hit_all  = hit_num && (pos_id == key_id);

	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_slot  = '0;
		for (int i = stidm_pkg::MAX_ENTRIES - 1; i >= 0; i--) begin
			if (!in_use_q[i]) begin
				free_found = 1'b1;
				free_slot  = stidm_pkg::IDX_W'(i);
			end
		end
	end

	// operation decode
	always_comb begin
		do_ins     = 1'b0;
		do_del     = 1'b0;
		res_status = stidm_pkg::ST_NOT_FOUND;
		res_slot   = '0;
		unique case (mode_q)
			stidm_pkg::MODE_CREATE: begin
				if (ver_q == '0) begin
					res_status = stidm_pkg::ST_ZERO_VERSION;
				end else if (count_q >= stidm_pkg::CNT_W'(stidm_pkg::MAX_ENTRIES)) begin
					res_status = stidm_pkg::ST_FULL;
				end else if (hit_num) begin
					res_status = stidm_pkg::ST_DUPLICATE;
				end else if (!free_found) begin
					res_status = stidm_pkg::ST_FULL;
				end else begin
					do_ins     = 1'b1;
					res_status = stidm_pkg::ST_OK;
					res_slot   = free_slot;
				end
			end
			stidm_pkg::MODE_FIND: begin
				if (hit_all) begin
					res_status = stidm_pkg::ST_OK;
					res_slot   = pos_slot;
				end
			end
			stidm_pkg::MODE_DELETE: begin
				if (hit_all) begin
					do_del     = 1'b1;
					res_status = stidm_pkg::ST_OK;
					res_slot   = pos_slot;
				end
			end
			default: begin
				res_status = stidm_pkg::ST_NOT_FOUND;
			end
		endcase
	end

	// list shift, bitmap and count updates
	always_comb begin
		in_use_nxt = in_use_q;
		count_nxt  = count_q;
		for (int i = 0; i < stidm_pkg::MAX_ENTRIES; i++) begin
			sorted_nxt[i] = sorted_q[i];
			if (do_ins) begin
				if (i == int'(lo_q)) begin
					sorted_nxt[i] = free_slot;
				end else if (i > int'(lo_q) && i <= int'(count_q)) begin
					sorted_nxt[i] = sorted_q[stidm_pkg::IDX_W'(i - 1)];
				end
			end else if (do_del) begin
				if (i >= int'(lo_q) && i + 1 < int'(count_q)) begin
					sorted_nxt[i] = sorted_q[stidm_pkg::IDX_W'(i + 1)];
				end
			end
		end
		if (do_ins) begin
			in_use_nxt[free_slot] = 1'b1;
			count_nxt = count_q + 1'b1;
		end else if (do_del) begin
			in_use_nxt[pos_slot] = 1'b0;
			count_nxt = count_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
			count_q  <= '0;
		end else if (cmd.commit) begin
			in_use_q <= in_use_nxt;
			count_q  <= count_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			num_q  <= thread_number;
			ver_q  <= version;
			lo_q   <= '0;
			hi_q   <= count_q;
		end
		if (cmd.step) begin
			if (mid_num < num_q) begin
				lo_q <= stidm_pkg::CNT_W'(mid) + 1'b1;
			end else begin
				hi_q <= stidm_pkg::CNT_W'(mid);
			end
		end
		if (cmd.commit) begin
			status_q  <= res_status;
			slot_q    <= res_slot;
			cnt_out_q <= count_nxt;
			sorted_q  <= sorted_nxt;
			if (do_ins) begin
				ids_q[free_slot] <= key_id;
			end
		end
	end

	assign status      = status_q;
	assign slot        = slot_q;
	assign entry_count = cnt_out_q;

endmodule

/* design/sorted_thread_id_map_top.sv */
// sorted_thread_id_map_top: thread id map, controller plus datapath
// depends on stidm_pkg, stidm_ctrl, stidm_dp
// from an accepted start the block loads the request, runs its binary search steps (none for an empty list)
// and commits, and the registered done strobe follows the commit
// throughput: a new start is taken in the cycle done is shown; busy is high in between
// reset clears the entry count and slot bitmap at once; no clearing pass is needed

module sorted_thread_id_map_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [stidm_pkg::MODE_W-1:0]       mode,
	input  logic [stidm_pkg::NUMBER_BITS-1:0]  thread_number,
	input  logic [stidm_pkg::VERSION_BITS-1:0] version,
	output logic                               done,
	output logic [stidm_pkg::STAT_W-1:0]       status,
	output logic [stidm_pkg::IDX_W-1:0]        slot,
	output logic [stidm_pkg::CNT_W-1:0]        entry_count
);

	stidm_pkg::cmd_t  cmd;
	stidm_pkg::stat_t stat;

	stidm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.stat   (stat),
		.cmd    (cmd)
	);

	stidm_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.mode          (mode),
		.thread_number (thread_number),
		.version       (version),
		.status        (status),
		.slot          (slot),
		.entry_count   (entry_count)
	);

endmodule

/* design/stidm_chk.sv */
// stidm_chk: port-level checks for sorted_thread_id_map_top, bound to the top level
// depends on stidm_pkg

module stidm_chk (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               start,
	input logic                               busy,
	input logic                               done,
	input logic [stidm_pkg::STAT_W-1:0]       status,
	input logic [stidm_pkg::IDX_W-1:0]        slot,
	input logic [stidm_pkg::CNT_W-1:0]        entry_count
);

	// a transaction keeps the block busy and gives no result in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted transaction did not raise busy");

	// a result ends the transaction
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// failed operations report slot zero
	a_fail_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != stidm_pkg::ST_OK) |-> (slot == '0))
		else $error("nonzero slot on failed operation");

	// count never exceeds the store
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (entry_count <= stidm_pkg::CNT_W'(stidm_pkg::MAX_ENTRIES)))
		else $error("entry count out of range");

	// a full table only reported with every slot taken
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == stidm_pkg::ST_FULL) |->
		(entry_count == stidm_pkg::CNT_W'(stidm_pkg::MAX_ENTRIES)))
		else $error("table full reported below capacity");

endmodule

bind sorted_thread_id_map_top stidm_chk u_stidm_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.status      (status),
	.slot        (slot),
	.entry_count (entry_count)
);
